// ===== src/assert_macros.svh =====
// assertion macros used by the palindrome check unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/rpc_pkg.sv =====
// constants for the radix palindrome check unit
`timescale 1ns / 1ps

package rpc_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int MAX_DIGITS_DEF = 32;

  // field widths fixed by the interface
  localparam int RADIX_W = 6;
  localparam int COUNT_W = 5;

  // legal radix range
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

endpackage

// ===== src/radix_palindrome_check_unit.sv =====
// radix palindrome check: bit-serial digit extraction and end-to-end digit compare
//
//  channel | signals                              | dir
//  --------+--------------------------------------+-----
//  in      | in_valid, in_ready, value, radix     | in
//  out     | out_valid, out_ready, is_palindrome, | out
//          | digit_count, status                  |
//
// one word at a time; each digit comes from a restoring division of the value left over
// (one quotient bit per cycle), and each digit pair is compared in the lo-read, hi-read
// and compare states (S_CMP_LO, S_CMP_HI, S_CMP_EQ).
// a bad radix or a zero value goes straight to the done state.
// rst is synchronous and clears control state; the digit store needs no clearing.
// a result waiting on out_ready holds the next word in the done state.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module radix_palindrome_check_unit
  import rpc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RADIX_W-1:0]    radix,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  is_palindrome,
  output logic [COUNT_W-1:0]    digit_count,
  output logic                  status
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int BW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CMP_LO,
    S_CMP_HI,
    S_CMP_EQ,
    S_DONE
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] quo;
  logic [RADIX_W-1:0]    radix_r;
  logic [RADIX_W-1:0]    rem;
  logic [BW-1:0]         bit_cnt;
  logic [CW-1:0]         cnt;
  logic [AW-1:0]         lo;
  logic [AW-1:0]         hi;
  logic [RADIX_W-1:0]    lo_dig;
  logic                  res_pal;
  logic                  res_status;

  // digit store
  logic [RADIX_W-1:0]    mem [MAX_DIGITS];
  logic [RADIX_W-1:0]    rd_data;
  logic [AW-1:0]         rd_addr;
  logic                  mem_we;

  // division step
  logic [RADIX_W:0]      rem_sh;
  logic                  qbit;
  logic [RADIX_W-1:0]    rem_new;
  logic [VALUE_BITS-1:0] quo_new;
  logic                  last_bit;
  logic [CW-1:0]         cnt_inc;
  logic [AW-1:0]         lo_next;
  logic [AW-1:0]         hi_next;
  logic [CW+COUNT_W-1:0] cnt_ext;
  logic                  bad_radix;

  // one restoring division step per cycle
  always_comb begin
    rem_sh   = {rem, quo[VALUE_BITS-1]};
    qbit     = (rem_sh >= {1'b0, radix_r});
    rem_new  = qbit ? RADIX_W'(rem_sh - {1'b0, radix_r}) : rem_sh[RADIX_W-1:0];
    quo_new  = {quo[VALUE_BITS-2:0], qbit};
    last_bit = (bit_cnt == BW'(VALUE_BITS - 1));
    cnt_inc  = cnt + CW'(1);
    lo_next  = lo + AW'(1);
    hi_next  = hi - AW'(1);
    cnt_ext  = {{COUNT_W{1'b0}}, cnt};
    bad_radix = (radix < RADIX_MIN) || (radix > RADIX_MAX);
  end

  assign in_ready = (state == S_IDLE);
  assign mem_we   = (state == S_DIV) && last_bit;
  assign rd_addr  = (state == S_CMP_LO) ? lo : hi;

  // digit store write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt[AW-1:0]] <= rem_new;
    end
    rd_data <= mem[rd_addr];
  end

  // control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result taken; the done state reloads the output itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            quo        <= value;
            radix_r    <= radix;
            rem        <= '0;
            bit_cnt    <= '0;
            cnt        <= '0;
            res_status <= bad_radix;
            res_pal    <= !bad_radix;
            if (bad_radix || (value == '0)) begin
              state <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          quo <= quo_new;
          if (last_bit) begin
            bit_cnt <= '0;
            rem     <= '0;
            cnt     <= cnt_inc;
            if ((quo_new == '0) || (cnt_inc == CW'(MAX_DIGITS))) begin
              lo <= '0;
              hi <= cnt[AW-1:0];
              if (cnt == '0) begin
                state <= S_DONE;
              end else begin
                state <= S_CMP_LO;
              end
            end
          end else begin
            rem     <= rem_new;
            bit_cnt <= bit_cnt + BW'(1);
          end
        end
        S_CMP_LO: begin
          state <= S_CMP_HI;
        end
        S_CMP_HI: begin
          lo_dig <= rd_data;
          state  <= S_CMP_EQ;
        end
        S_CMP_EQ: begin
          lo <= lo_next;
          hi <= hi_next;
          if (lo_dig != rd_data) begin
            res_pal <= 1'b0;
            state   <= S_DONE;
          end else if (lo_next < hi_next) begin
            state <= S_CMP_LO;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            is_palindrome <= res_pal;
            digit_count   <= cnt_ext[COUNT_W-1:0];
            status        <= res_status;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `ASSERT_IMP(a_bad_radix_zero, clk, rst, out_valid && status, (digit_count == '0) && !is_palindrome)
  `ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_IMP(a_count_bound, clk, rst, state != S_IDLE, cnt <= CW'(MAX_DIGITS))

endmodule

// ===== bench/rpc_result_checker.sv =====
// result checker for the radix palindrome check unit: predicts each result and compares it
`timescale 1ns / 1ps

module rpc_result_checker
  import rpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [VALUE_BITS_DEF-1:0] value,
  input  logic [RADIX_W-1:0]        radix,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      is_palindrome,
  input  logic [COUNT_W-1:0]        digit_count,
  input  logic                      status,
  output int                        fail_count,
  output int                        outstanding,
  output int                        checked
);

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_BAD_RADIX = 1'b1;
  localparam int   REPORT_MAX   = 10;

  typedef struct packed {
    logic               is_pal;
    logic [COUNT_W-1:0] count;
    logic               status;
  } pal_verdict_t;

  pal_verdict_t verdict_q[$];
  int           mismatches = 0;
  int           compared   = 0;

  // digit-by-digit conversion followed by an end-to-end digit compare
  function automatic pal_verdict_t predict_verdict(input logic [VALUE_BITS_DEF-1:0] v,
                                                   input logic [RADIX_W-1:0] r);
    pal_verdict_t      res;
    logic [RADIX_W-1:0] digs [MAX_DIGITS_DEF];
    longint unsigned   rest;
    int                n;
    int                lo;
    int                hi;
    res.is_pal = 1'b1;
    res.count  = '0;
    res.status = ST_OK;
    // bad radix: nothing converted, both fields forced low
    if (r < RADIX_MIN || r > RADIX_MAX) begin
      res.is_pal = 1'b0;
      res.status = ST_BAD_RADIX;
      return res;
    end
    rest = v;
    n    = 0;
    while (rest != 0 && n < MAX_DIGITS_DEF) begin
      digs[n] = RADIX_W'(rest % r);
      rest    = rest / r;
      n++;
    end
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      if (digs[lo] != digs[hi]) res.is_pal = 1'b0;
      lo++;
      hi--;
    end
    res.count = COUNT_W'(n);
    return res;
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk) begin : watch
    pal_verdict_t want;
    pal_verdict_t got;
    if (rst) begin
      verdict_q.delete();
      mismatches = 0;
      compared   = 0;
    end else begin
      // results first, so the oldest expectation is taken before a new word lands
      if (out_valid && out_ready) begin
        got.is_pal = is_palindrome;
        got.count  = digit_count;
        got.status = status;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result: pal=%0b count=%0d status=%0b",
                     got.is_pal, got.count, got.status);
        end else begin
          want = verdict_q.pop_front();
          compared++;
          if (got.is_pal !== want.is_pal || got.count !== want.count ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch on result %0d: expected pal=%0b count=%0d status=%0b, got pal=%0b count=%0d status=%0b",
                       compared, want.is_pal, want.count, want.status,
                       got.is_pal, got.count, got.status);
          end
        end
      end
      if (in_valid && in_ready) verdict_q.push_back(predict_verdict(value, radix));
    end
    fail_count  <= mismatches;
    outstanding <= verdict_q.size();
    checked     <= compared;
  end

endmodule

// ===== bench/radix_palindrome_check_unit_test.sv =====
// top of the radix palindrome check unit bench: clock, reset, word stimulus and verdict
`timescale 1ns / 1ps

module radix_palindrome_check_unit_test;
  import rpc_pkg::*;

  localparam int VB             = VALUE_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 1100;
  localparam int PHASE_WORDS    = 104;
  localparam int PHASES         = 5;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [VB-1:0]      value         = '0;
  logic [RADIX_W-1:0] radix         = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic               is_palindrome;
  logic [COUNT_W-1:0] digit_count;
  logic               status;

  int fail_count;
  int outstanding;
  int checked;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int words_sent    = 0;
  int quiet_cycles  = 0;

  radix_palindrome_check_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .value         (value),
    .radix         (radix),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_palindrome (is_palindrome),
    .digit_count   (digit_count),
    .status        (status)
  );

  rpc_result_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .value         (value),
    .radix         (radix),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_palindrome (is_palindrome),
    .digit_count   (digit_count),
    .status        (status),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked       (checked)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one word, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_word(input logic [VB-1:0] v, input logic [RADIX_W-1:0] r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    radix    <= r;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // hold the sender off until every expected result has come back
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // build a random palindrome in base r, mostly with few digits
  function automatic logic [VB-1:0] make_palindrome(input int r);
    longint unsigned lim;
    longint unsigned acc;
    longint unsigned val;
    int              digs [32];
    int              maxn;
    int              n;
    int              i;
    lim  = (64'd1 << VB) - 1;
    acc  = lim;
    maxn = 0;
    while (acc != 0) begin
      acc = acc / r;
      maxn++;
    end
    if ($urandom_range(3) != 0) n = $urandom_range(1, (maxn < 8) ? maxn : 8);
    else n = $urandom_range(1, maxn);
    do begin
      for (i = 0; i < (n + 1) / 2; i++) begin
        digs[i]         = (i == 0) ? $urandom_range(1, r - 1) : $urandom_range(0, r - 1);
        digs[n - 1 - i] = digs[i];
      end
      val = 0;
      for (i = 0; i < n; i++) val = val * r + digs[i];
      if (val > lim) n--;
    end while (val > lim);
    return VB'(val);
  endfunction

  initial begin : stim
    int                 phase;
    int                 k;
    int                 sel;
    int                 w;
    int                 rv;
    logic [VB-1:0]      v;
    logic [RADIX_W-1:0] r;
    int                 idle_tab  [PHASES];
    int                 stall_tab [PHASES];
    idle_tab  = '{0, 73, 0, 23, 0};
    stall_tab = '{0, 0, 73, 23, 0};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words: zero, single digits, extremes, bad radices, known palindromes
    send_word('0, 6'd10);
    send_word('0, 6'd2);
    send_word('0, 6'd36);
    send_word('0, 6'd0);
    send_word({VB{1'b1}}, 6'd2);
    send_word({VB{1'b1}}, 6'd36);
    send_word({VB{1'b1}}, 6'd63);
    send_word(VB'(32'h4000_0000), 6'd2);
    send_word(VB'(1), 6'd2);
    send_word(VB'(35), 6'd36);
    send_word(VB'(36), 6'd36);
    send_word(VB'(37), 6'd36);
    send_word(VB'(121), 6'd10);
    send_word(VB'(12321), 6'd10);
    send_word(VB'(123), 6'd10);
    send_word(VB'(100), 6'd10);
    send_word(VB'(5), 6'd1);
    send_word(VB'(9), 6'd37);
    send_word(VB'(32'h5555_5555), 6'd2);
    send_word(VB'(32'h2AAA_AAAA), 6'd2);
    send_word(VB'(32'h0000_ABBA), 6'd16);
    send_word({VB{1'b1}}, 6'd10);
    hold_until_drained();

    // random words under each handshake phase
    for (phase = 0; phase < PHASES; phase++) begin
      send_idle_pct = idle_tab[phase];
      stall_pct     = stall_tab[phase];
      for (k = 0; k < PHASE_WORDS; k++) begin
        sel = $urandom_range(99);
        rv  = $urandom_range(RADIX_MIN, RADIX_MAX);
        if (sel < 40) begin
          v = make_palindrome(rv);
        end else if (sel < 55) begin
          // palindrome with one bit flipped
          v = make_palindrome(rv) ^ (VB'(1) << $urandom_range(VB - 1));
        end else begin
          w = $urandom_range(1, VB);
          v = VB'(longint'($urandom) & ((64'd1 << w) - 1));
        end
        if (sel >= 90) begin
          // out-of-range radix: 0, 1 or 37..63
          rv = $urandom_range(0, 28);
          rv = (rv < 2) ? rv : rv + 35;
        end
        r = RADIX_W'(rv);
        send_word(v, r);
      end
      hold_until_drained();
    end

    stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d words (22 directed, the rest random), %0d results compared",
             words_sent, checked);
    $display("phases ran free, with a sparse sender, a stalling receiver and both mixed");
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, outstanding);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/rpc_pkg.sv
src/radix_palindrome_check_unit.sv
bench/rpc_result_checker.sv
bench/radix_palindrome_check_unit_test.sv
